FILE: rtl/core/lmf_pkg.sv
// Shared types, constants and helper functions for the logistic MF SGD core.
package lmf_pkg;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TS_USER_FAC = 2'd0,
    TS_ITEM_FAC = 2'd1,
    TS_USER_BIAS = 2'd2,
    TS_ITEM_BIAS = 2'd3
  } tsel_e;

  localparam int MulAW = 32;
  localparam int MulBW = 34;
  localparam int MulPW = MulAW + MulBW;

  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam int ClampQ16 = 8 * 65536;

  function automatic logic [16:0] sig_tab(input logic [4:0] j);
    logic [16:0] y;
    case (j)
      5'd0:  y = 17'd32768;
      5'd1:  y = 17'd40793;
      5'd2:  y = 17'd47911;
      5'd3:  y = 17'd53581;
      5'd4:  y = 17'd57724;
      5'd5:  y = 17'd60565;
      5'd6:  y = 17'd62428;
      5'd7:  y = 17'd63615;
      5'd8:  y = 17'd64357;
      5'd9:  y = 17'd64816;
      5'd10: y = 17'd65097;
      5'd11: y = 17'd65269;
      5'd12: y = 17'd65374;
      5'd13: y = 17'd65438;
      5'd14: y = 17'd65476;
      5'd15: y = 17'd65500;
      default: y = 17'd65514;
    endcase
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MulPW-1:0] v);
    logic signed [31:0] r;
    if (v > MulPW'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -MulPW'(64'sd2147483648)) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

FILE: rtl/core/logistic_mf_sgd_update_core.sv
// Top level: logistic matrix factorisation SGD update core.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | opcode .. write_value
//  out     | output    | out_valid_o / out_stall_i | read_value, prediction, error_value
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One item at a time; the shared multiplier sets the length.
// A train item with factors uses the multiplier for every factor element, first for the
// dot product and then for the user and item factor updates.
// Reset idles control, sets config to 655; table contents are undefined until written.
// The output register holds a result until taken; no item is accepted meanwhile.
module logistic_mf_sgd_update_core #(
  parameter int FACTORS = 16,
  parameter int USERS   = 1024,
  parameter int ITEMS   = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         user_id_i,
  input  logic [9:0]         item_id_i,
  input  logic               label_i,
  input  logic               factors_on_i,
  input  logic [1:0]         table_select_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] write_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [16:0]        prediction_o,
  output logic signed [17:0] error_value_o
);
  import lmf_pkg::*;

  localparam int UBW = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int IBW = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam int UFW = $clog2(USERS * FACTORS);
  localparam int IFW = $clog2(ITEMS * FACTORS);
  localparam int KW  = (FACTORS > 1) ? $clog2(FACTORS) : 1;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DEC   = 5'd1;
  localparam logic [4:0] ST_BWAIT = 5'd2;
  localparam logic [4:0] ST_DADDR = 5'd3;
  localparam logic [4:0] ST_DMUL  = 5'd4;
  localparam logic [4:0] ST_DACC  = 5'd5;
  localparam logic [4:0] ST_SIG0  = 5'd6;
  localparam logic [4:0] ST_SIG1  = 5'd7;
  localparam logic [4:0] ST_G1    = 5'd8;
  localparam logic [4:0] ST_G2    = 5'd9;
  localparam logic [4:0] ST_G3    = 5'd10;
  localparam logic [4:0] ST_G4    = 5'd11;
  localparam logic [4:0] ST_FADDR = 5'd12;
  localparam logic [4:0] ST_FRD   = 5'd13;
  localparam logic [4:0] ST_FG    = 5'd14;
  localparam logic [4:0] ST_FG2   = 5'd15;
  localparam logic [4:0] ST_RWAIT = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  localparam logic [1:0] JOB_UB = 2'd0;
  localparam logic [1:0] JOB_IB = 2'd1;
  localparam logic [1:0] JOB_UF = 2'd2;
  localparam logic [1:0] JOB_IF = 2'd3;

  logic [4:0]  state_q, state_d;
  logic [15:0] lr_q, rw_q;

  op_e                op_q;
  logic [9:0]         uid_q, iid_q;
  logic               label_q, fon_q;
  tsel_e              tsel_q;
  logic [3:0]         el_q;
  logic signed [31:0] wval_q;

  logic [KW-1:0]      k_q, k_d;
  logic [1:0]         job_q, job_d;
  logic signed [55:0] score_q, score_d;
  logic signed [31:0] ub_old_q, ub_old_d, ib_old_q, ib_old_d;
  logic signed [31:0] p_q, p_d, q_q, q_d, v_q, v_d;
  logic signed [33:0] g_q, g_d, t_q, t_d;
  logic [4:0]         j_q, j_d;
  logic               neg_q, neg_d;
  logic signed [31:0] read_q, read_d;
  logic [16:0]        pred_q, pred_d;
  logic signed [17:0] err_q, err_d;

  logic signed [31:0] ub_mem [USERS];
  logic signed [31:0] ib_mem [ITEMS];
  logic signed [31:0] uf_mem [USERS * FACTORS];
  logic signed [31:0] if_mem [ITEMS * FACTORS];
  logic signed [31:0] ub_rd, ib_rd, uf_rd, if_rd;
  logic [UBW-1:0] ub_a;
  logic [IBW-1:0] ib_a;
  logic [UFW-1:0] uf_a;
  logic [IFW-1:0] if_a;
  logic ub_we, ib_we, uf_we, if_we;
  logic signed [31:0] ub_wd, ib_wd, uf_wd, if_wd;

  mul_req_t           mreq;
  logic signed [MulPW-1:0] prod, prod_sh;

  logic in_acc, uid_ok, iid_ok, el_ok, cell_ok;
  logic [6:0] idx;
  logic signed [20:0] xcl;
  logic [19:0] aabs;
  logic [13:0] diff;
  logic [16:0] y;
  logic signed [31:0] sgd_res;

  lmf_mul u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .prod_o(prod)
  );

  assign prod_sh = prod >>> 16;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign read_value_o  = read_q;
  assign prediction_o  = pred_q;
  assign error_value_o = err_q;

  assign uid_ok = int'(uid_q) < USERS;
  assign iid_ok = int'(iid_q) < ITEMS;
  assign el_ok  = int'(el_q) < FACTORS;
  assign idx    = (state_q == ST_DEC || state_q == ST_RWAIT) ? 7'(el_q) : 7'(k_q);

  assign ub_a = UBW'(uid_q);
  assign ib_a = IBW'(iid_q);
  assign uf_a = UFW'(int'(uid_q) * FACTORS + int'(idx));
  assign if_a = IFW'(int'(iid_q) * FACTORS + int'(idx));

  always_comb begin
    case (tsel_q)
      TS_USER_FAC:  cell_ok = uid_ok && el_ok;
      TS_ITEM_FAC:  cell_ok = iid_ok && el_ok;
      TS_USER_BIAS: cell_ok = uid_ok;
      default:      cell_ok = iid_ok;
    endcase
  end

  // sigmoid front end
  always_comb begin
    if (score_q > 56'(ClampQ16)) xcl = 21'(ClampQ16);
    else if (score_q < -56'(ClampQ16)) xcl = -21'(ClampQ16);
    else xcl = 21'(score_q);
    aabs = xcl[20] ? 20'(-xcl) : 20'(xcl);
    diff = (aabs[19:15] < 5'd16) ?
           14'(sig_tab(aabs[19:15] + 5'd1) - sig_tab(aabs[19:15])) : 14'd0;
    y = sig_tab(j_q) + 17'(prod[27:15]);
  end

  assign sgd_res = sat32(MulPW'(v_q) + prod_sh);

  // multiplier operand select
  always_comb begin
    mreq = '0;
    case (state_q)
      ST_DMUL: begin
        mreq.en = 1'b1;
        mreq.a  = uf_rd;
        mreq.b  = MulBW'(if_rd);
      end
      ST_SIG0: begin
        mreq.en = 1'b1;
        mreq.a  = MulAW'({18'd0, diff});
        mreq.b  = MulBW'({19'd0, aabs[14:0]});
      end
      ST_G1: begin
        mreq.en = 1'b1;
        mreq.a  = MulAW'({16'd0, rw_q});
        mreq.b  = MulBW'(v_q);
      end
      ST_G3: begin
        mreq.en = 1'b1;
        mreq.a  = MulAW'({16'd0, lr_q});
        mreq.b  = t_q;
      end
      ST_FG: begin
        mreq.en = 1'b1;
        mreq.a  = MulAW'(err_q);
        mreq.b  = (job_q == JOB_UF) ? MulBW'(q_q) : MulBW'(p_q);
      end
      default: mreq = '0;
    endcase
  end

  // memory write select
  always_comb begin
    ub_we = 1'b0; ib_we = 1'b0; uf_we = 1'b0; if_we = 1'b0;
    ub_wd = sgd_res; ib_wd = sgd_res; uf_wd = sgd_res; if_wd = sgd_res;
    if (state_q == ST_DEC && op_q == OP_WRITE && cell_ok) begin
      ub_wd = wval_q; ib_wd = wval_q; uf_wd = wval_q; if_wd = wval_q;
      case (tsel_q)
        TS_USER_FAC:  uf_we = 1'b1;
        TS_ITEM_FAC:  if_we = 1'b1;
        TS_USER_BIAS: ub_we = 1'b1;
        default:      ib_we = 1'b1;
      endcase
    end else if (state_q == ST_G4) begin
      case (job_q)
        JOB_UB:  ub_we = 1'b1;
        JOB_IB:  ib_we = 1'b1;
        JOB_UF:  uf_we = 1'b1;
        default: if_we = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ub_we) ub_mem[ub_a] <= ub_wd;
    ub_rd <= ub_mem[ub_a];
  end
  always_ff @(posedge clk_i) begin
    if (ib_we) ib_mem[ib_a] <= ib_wd;
    ib_rd <= ib_mem[ib_a];
  end
  always_ff @(posedge clk_i) begin
    if (uf_we) uf_mem[uf_a] <= uf_wd;
    uf_rd <= uf_mem[uf_a];
  end
  always_ff @(posedge clk_i) begin
    if (if_we) if_mem[if_a] <= if_wd;
    if_rd <= if_mem[if_a];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d = k_q; job_d = job_q; score_d = score_q;
    ub_old_d = ub_old_q; ib_old_d = ib_old_q;
    p_d = p_q; q_d = q_q; v_d = v_q; g_d = g_q; t_d = t_q;
    j_d = j_q; neg_d = neg_q;
    read_d = read_q; pred_d = pred_q; err_d = err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DEC;
          read_d = '0; pred_d = '0; err_d = '0;
          k_d = '0;
        end
      end
      ST_DEC: begin
        case (op_q)
          OP_TRAIN: state_d = (uid_ok && iid_ok) ? ST_BWAIT : ST_OUT;
          OP_READ:  state_d = cell_ok ? ST_RWAIT : ST_OUT;
          default:  state_d = ST_OUT;
        endcase
      end
      ST_RWAIT: begin
        case (tsel_q)
          TS_USER_FAC:  read_d = uf_rd;
          TS_ITEM_FAC:  read_d = if_rd;
          TS_USER_BIAS: read_d = ub_rd;
          default:      read_d = ib_rd;
        endcase
        state_d = ST_OUT;
      end
      ST_BWAIT: begin
        ub_old_d = ub_rd;
        ib_old_d = ib_rd;
        score_d = 56'(ub_rd) + 56'(ib_rd);
        state_d = fon_q ? ST_DADDR : ST_SIG0;
      end
      ST_DADDR: state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DACC;
      ST_DACC: begin
        score_d = score_q + 56'(prod_sh);
        if (k_q == KW'(FACTORS - 1)) begin
          k_d = '0;
          state_d = ST_SIG0;
        end else begin
          k_d = k_q + KW'(1);
          state_d = ST_DADDR;
        end
      end
      ST_SIG0: begin
        j_d = aabs[19:15];
        neg_d = xcl[20];
        state_d = ST_SIG1;
      end
      ST_SIG1: begin
        pred_d = neg_q ? 17'(OneQ16 - y) : y;
        err_d = label_q ? 18'(18'(OneQ16) - 18'(pred_d)) : -18'(pred_d);
        v_d = ub_old_q;
        g_d = 34'(err_d);
        job_d = JOB_UB;
        state_d = ST_G1;
      end
      ST_G1: state_d = ST_G2;
      ST_G2: begin
        t_d = 34'(MulPW'(g_q) - prod_sh);
        state_d = ST_G3;
      end
      ST_G3: state_d = ST_G4;
      ST_G4: begin
        case (job_q)
          JOB_UB: begin
            job_d = JOB_IB;
            v_d = ib_old_q;
            g_d = 34'(err_q);
            state_d = ST_G1;
          end
          JOB_IB: state_d = fon_q ? ST_FADDR : ST_OUT;
          JOB_UF: begin
            job_d = JOB_IF;
            state_d = ST_FG;
          end
          default: begin
            if (k_q == KW'(FACTORS - 1)) begin
              state_d = ST_OUT;
            end else begin
              k_d = k_q + KW'(1);
              state_d = ST_FADDR;
            end
          end
        endcase
      end
      ST_FADDR: state_d = ST_FRD;
      ST_FRD: begin
        p_d = uf_rd;
        q_d = if_rd;
        job_d = JOB_UF;
        state_d = ST_FG;
      end
      ST_FG: state_d = ST_FG2;
      ST_FG2: begin
        g_d = 34'(prod_sh);
        v_d = (job_q == JOB_UF) ? p_q : q_q;
        state_d = ST_G1;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lr_q <= 16'd655;
      rw_q <= 16'd655;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i) rw_q <= cfg_data_i;
        else lr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_e'(opcode_i);
      uid_q <= user_id_i;
      iid_q <= item_id_i;
      label_q <= label_i;
      fon_q <= factors_on_i;
      tsel_q <= tsel_e'(table_select_i);
      el_q <= element_index_i;
      wval_q <= write_value_i;
    end
    k_q <= k_d; job_q <= job_d; score_q <= score_d;
    ub_old_q <= ub_old_d; ib_old_q <= ib_old_d;
    p_q <= p_d; q_q <= q_d; v_q <= v_d; g_q <= g_d; t_q <= t_d;
    j_q <= j_d; neg_q <= neg_d;
    read_q <= read_d; pred_q <= pred_d; err_q <= err_d;
  end

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item accepted while result pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");
  a_pred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prediction_o <= OneQ16)) else $error("prediction out of range");
  a_non_train_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op_q != OP_TRAIN) |-> (prediction_o == '0 && error_value_o == '0))
    else $error("non-train result carries prediction");

endmodule

FILE: rtl/core/lmf_mul.sv
// Shared signed multiplier with registered product.
module lmf_mul (
  input  logic                            clk_i,
  input  lmf_pkg::mul_req_t               req_i,
  output logic signed [lmf_pkg::MulPW-1:0] prod_o
);
  import lmf_pkg::*;

  logic signed [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MulPW'(req_i.a) * MulPW'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule
